@@ design/sva_pkg.sv @@
// Package for the voice allocator: constants, command, status and CSR codes, FSM states.
// No dependencies.
`default_nettype none
package sva_pkg;
   localparam int MaxVoicesDef = 64;
   localparam int MaxCoresDef = 4;
   localparam logic [6:0] CpuLimit = 7'd90;
   localparam logic [15:0] LoadCeiling = 16'd1000;
   localparam logic [7:0] NoNote = 8'd255;
   localparam logic [4:0] NoProgram = 5'd31;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_READ = 4'd2, CMD_CLEAR = 4'd3,
      CMD_LEAST = 4'd4, CMD_FREE = 4'd5, CMD_OLDEST = 4'd6, CMD_REUSE = 4'd7,
      CMD_ACTIVATE = 4'd8, CMD_RELEASE = 4'd9, CMD_DONE = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_RANGE = 2'd1, ST_CPU = 2'd2, ST_NONE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_VOICES = 3'd0, CSR_CORES = 3'd1, CSR_VPC = 3'd2, CSR_PROGS = 3'd3,
      CSR_WEIGHT = 3'd4
   } csr_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_VREAD, S_VWRITE, S_LOAD, S_RESP
   } state_type;
endpackage
`default_nettype wire

@@ design/sva_voice_mem.sv @@
// Voice table memory: one write port and one registered read port.
// Depends on sva_pkg.
`default_nettype none
module sva_voice_mem import sva_pkg::*; #(
   parameter int MaxVoices = MaxVoicesDef,
   localparam int Aw = (MaxVoices > 1) ? $clog2(MaxVoices) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [Aw-1:0] wr_addr,
   input  wire logic [46:0]   wr_data,
   input  wire logic [Aw-1:0] rd_addr,
   output logic [46:0]        rd_data_ff
);
   logic [46:0] mem [MaxVoices];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/synth_voice_allocator_top.sv @@
// Top level of the voice allocator: command sequencer, core loads and config.
// Depends on sva_pkg and sva_voice_mem.
`default_nettype none
// One request is processed at a time, and the next request is taken only after the
// response has been accepted. Load commands pass through a load state and a response
// state, least core through an empty scan and the response state. Voice updates (activate,
// release, done) read the entry, write the update, adjust the core load where needed and respond.
// The free, oldest and reuse searches read the voice table one entry per cycle through its
// single read port: all configured voices for oldest and reuse, one core group for free. A
// response that waits for rsp_ready holds off the next request for as long as it waits.
// After reset a clearing pass writes every voice entry, one per cycle, and no request is
// taken before it ends.
module synth_voice_allocator_top import sva_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_command,
   input  wire logic [5:0]  req_voice_index,
   input  wire logic [1:0]  req_core_index,
   input  wire logic [6:0]  req_note_number,
   input  wire logic [3:0]  req_program_number,
   input  wire logic [7:0]  req_load_amount,
   input  wire logic        req_release_pending,
   input  wire logic [31:0] req_time_ms,
   input  wire logic [6:0]  req_cpu_percent,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_found_index,
   output logic [15:0]      rsp_load_value,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);
   localparam int MaxVoices = MaxVoicesDef;
   localparam int MaxCores = MaxCoresDef;
   localparam int Aw = (MaxVoices > 1) ? $clog2(MaxVoices) : 1;
   localparam int Cw = (MaxCores > 1) ? $clog2(MaxCores) : 1;
   localparam int Vw = Aw + 1;
   localparam logic [Vw-1:0] NVoices = Vw'(MaxVoices);
   localparam logic [4:0] NCores = 5'(MaxCores);

   state_type state_ff, state_in;
   logic [6:0] voices_ff;
   logic [2:0] cores_ff;
   logic [6:0] vpc_ff;
   logic [4:0] progs_ff;
   logic [7:0] weight_ff;
   logic [15:0] load_ff [MaxCores];

   logic [3:0] cmd_ff;
   logic [5:0] vi_ff;
   logic [1:0] ci_ff;
   logic [6:0] note_ff;
   logic [3:0] prog_ff;
   logic [7:0] amt_ff;
   logic pend_ff;
   logic [31:0] now_ff;
   logic [6:0] cpu_ff;

   logic [Vw-1:0] scan_ff, scan_in;
   logic [Vw-1:0] rd_idx_ff;
   logic [Vw-1:0] hi_ff;
   logic scan_rd_ff;
   logic hit_ff;
   logic [32:0] best_ff;
   logic [Vw-1:0] best_idx_ff;
   logic [1:0] status_ff;
   logic [5:0] found_ff;
   logic [15:0] loadv_ff;
   logic [1:0] rsp_status_ff;
   logic [5:0] rsp_found_ff;
   logic [15:0] rsp_load_ff;
   logic rsp_valid_ff;
   logic [Vw-1:0] vpc_sub_ff;
   logic [4:0] core_of_ff;

   logic [Vw-1:0] nv;
   logic [4:0] nc;
   logic mem_we;
   logic [Aw-1:0] mem_wa, mem_ra;
   logic [46:0] mem_wd, mem_rd;
   logic e_act, e_pend;
   logic [7:0] e_note;
   logic [4:0] e_prog;
   logic [31:0] e_time;
   logic accept;
   logic [Vw-1:0] free_lo, free_hi, free_end;
   logic [14:0] lo_prod;
   logic [15:0] hi_sum;

   assign nv = ({1'b0, voices_ff} > 8'(NVoices)) ? NVoices : Vw'(voices_ff);
   assign nc = ({2'b0, cores_ff} > NCores) ? NCores : 5'(cores_ff);
   assign {e_act, e_pend, e_note, e_prog, e_time} = mem_rd;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign lo_prod = 15'(req_core_index) * 15'(vpc_ff);
   assign hi_sum = 16'(lo_prod) + 16'(vpc_ff);
   assign free_lo = (lo_prod > 15'(nv)) ? nv : Vw'(lo_prod);
   assign free_end = (hi_sum > 16'(nv)) ? nv : Vw'(hi_sum);
   assign free_hi = free_end;

   sva_voice_mem #(.MaxVoices(MaxVoices)) u_mem (
      .clock, .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data_ff(mem_rd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (scan_ff == NVoices - Vw'(1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_FREE, CMD_OLDEST, CMD_REUSE, CMD_LEAST: state_in = S_SCAN;
                  CMD_ACTIVATE, CMD_RELEASE, CMD_DONE: state_in = S_VREAD;
                  default: state_in = S_LOAD;
               endcase
            end
         end
         S_SCAN: if (!scan_rd_ff && scan_ff >= hi_ff) state_in = S_RESP;
         S_VREAD: state_in = S_VWRITE;
         S_VWRITE: state_in = S_LOAD;
         S_LOAD: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      scan_in = scan_ff + Vw'(1);
      mem_ra = scan_ff[Aw-1:0];
      if (state_ff == S_VREAD || state_ff == S_VWRITE) mem_ra = vi_ff[Aw-1:0];
      mem_we = 1'b0;
      mem_wa = scan_ff[Aw-1:0];
      mem_wd = {1'b0, 1'b0, NoNote, NoProgram, 32'd0};
      if (state_ff == S_CLEAR) mem_we = 1'b1;
      if (state_ff == S_VWRITE && status_ff == ST_OK) begin
         mem_wa = vi_ff[Aw-1:0];
         unique case (cmd_ff)
            CMD_ACTIVATE: begin
               mem_we = 1'b1;
               mem_wd = {1'b1, 1'b0, {1'b0, note_ff}, {1'b0, prog_ff}, now_ff};
            end
            CMD_RELEASE: begin
               mem_we = 1'b1;
               if (pend_ff) mem_wd = {e_act, 1'b1, e_note, e_prog, e_time};
            end
            CMD_DONE: mem_we = e_act || e_pend;
            default: mem_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         voices_ff <= 7'd64;
         cores_ff <= 3'd4;
         vpc_ff <= 7'd16;
         progs_ff <= 5'd16;
         weight_ff <= 8'd1;
         scan_rd_ff <= 1'b0;
         for (int i = 0; i < MaxCores; i++) load_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_VOICES: voices_ff <= csr_write_data[6:0];
               CSR_CORES: cores_ff <= csr_write_data[2:0];
               CSR_VPC: vpc_ff <= csr_write_data[6:0];
               CSR_PROGS: progs_ff <= csr_write_data[4:0];
               CSR_WEIGHT: weight_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_CLEAR) scan_ff <= scan_in;
         if (accept) begin
            cmd_ff <= req_command;
            vi_ff <= req_voice_index;
            ci_ff <= req_core_index;
            note_ff <= req_note_number;
            prog_ff <= req_program_number;
            amt_ff <= req_load_amount;
            pend_ff <= req_release_pending;
            now_ff <= req_time_ms;
            cpu_ff <= req_cpu_percent;
            hit_ff <= 1'b0;
            best_ff <= {1'b1, 32'd0};
            best_idx_ff <= '0;
            status_ff <= ST_RANGE;
            found_ff <= '0;
            loadv_ff <= '0;
            scan_rd_ff <= 1'b0;
            vpc_sub_ff <= '0;
            hi_ff <= nv;
            scan_ff <= '0;
            if (req_command == CMD_FREE) begin
               scan_ff <= free_lo;
               hi_ff <= free_hi;
            end
            if (req_command == CMD_LEAST) hi_ff <= '0;
         end
         if (state_ff == S_SCAN) begin
            scan_rd_ff <= 1'b0;
            if (scan_ff < hi_ff) begin
               scan_ff <= scan_in;
               scan_rd_ff <= 1'b1;
               rd_idx_ff <= scan_ff;
            end
            if (scan_rd_ff) begin
               unique case (cmd_ff)
                  CMD_FREE: begin
                     if (!hit_ff && !e_act && !e_pend) begin
                        hit_ff <= 1'b1;
                        best_idx_ff <= rd_idx_ff;
                     end
                  end
                  CMD_OLDEST: begin
                     if ({1'b0, e_time} < best_ff) begin
                        hit_ff <= 1'b1;
                        best_ff <= {1'b0, e_time};
                        best_idx_ff <= rd_idx_ff;
                     end
                  end
                  default: begin
                     if ((e_act || e_pend) && e_note == {1'b0, note_ff}
                         && e_prog == {1'b0, prog_ff} && {1'b0, e_time} < best_ff) begin
                        hit_ff <= 1'b1;
                        best_ff <= {1'b0, e_time};
                        best_idx_ff <= rd_idx_ff;
                     end
                  end
               endcase
            end
         end
         if (state_ff == S_VREAD) begin
            status_ff <= ST_RANGE;
            found_ff <= '0;
            if ({1'b0, vi_ff} < 7'(nv) &&
                (cmd_ff != CMD_ACTIVATE || {1'b0, prog_ff} < progs_ff)) begin
               status_ff <= ST_OK;
               found_ff <= vi_ff;
            end
            vpc_sub_ff <= '0;
            core_of_ff <= '0;
         end
         if (state_ff == S_VWRITE) begin
            // Find the owning core by counting groups; MaxCores is small.
            core_of_ff <= 5'd31;
            for (int c = MaxCores - 1; c >= 0; c--) begin
               if (16'(vi_ff) < 16'(c + 1) * 16'(vpc_ff) &&
                   16'(vi_ff) >= 16'(c) * 16'(vpc_ff)) core_of_ff <= 5'(c);
            end
            vpc_sub_ff <= Vw'(0);
            if (status_ff == ST_OK && vpc_ff != 7'd0 &&
                ((cmd_ff == CMD_RELEASE && !pend_ff) ||
                 (cmd_ff == CMD_DONE && (e_act || e_pend)))) vpc_sub_ff <= Vw'(1);
         end
         if (state_ff == S_LOAD) begin
            unique case (cmd_ff)
               CMD_ADD, CMD_SUB, CMD_READ, CMD_CLEAR: begin
                  if ({3'b0, ci_ff} < nc && (cmd_ff[1] || amt_ff != 8'd0)) begin
                     logic [16:0] cur;
                     cur = {1'b0, load_ff[ci_ff[Cw-1:0]]};
                     if (cmd_ff == CMD_ADD) begin
                        cur = cur + 17'(amt_ff);
                        if (cur[16]) cur = 17'h0FFFF;
                     end else if (cmd_ff == CMD_SUB) begin
                        cur = (cur > 17'(amt_ff)) ? cur - 17'(amt_ff) : 17'd0;
                     end else if (cmd_ff == CMD_CLEAR) begin
                        cur = 17'd0;
                     end
                     load_ff[ci_ff[Cw-1:0]] <= cur[15:0];
                     status_ff <= ST_OK;
                     found_ff <= 6'(ci_ff);
                     loadv_ff <= cur[15:0];
                  end
               end
               default: begin
                  if (vpc_sub_ff != '0 && core_of_ff < nc && weight_ff != 8'd0) begin
                     load_ff[core_of_ff[Cw-1:0]] <=
                        (load_ff[core_of_ff[Cw-1:0]] > 16'(weight_ff)) ?
                        load_ff[core_of_ff[Cw-1:0]] - 16'(weight_ff) : 16'd0;
                  end
               end
            endcase
         end
         if (state_ff == S_RESP) begin
            rsp_valid_ff <= 1'b1;
            rsp_status_ff <= status_ff;
            rsp_found_ff <= found_ff;
            rsp_load_ff <= loadv_ff;
            unique case (cmd_ff)
               CMD_LEAST: begin
                  logic [15:0] b;
                  logic h;
                  logic [5:0] f;
                  b = LoadCeiling;
                  h = 1'b0;
                  f = '0;
                  for (int c = 0; c < MaxCores; c++) begin
                     if (5'(c) < nc && load_ff[c] < b) begin
                        b = load_ff[c];
                        h = 1'b1;
                        f = 6'(c);
                     end
                  end
                  rsp_status_ff <= h ? ST_OK : ST_NONE;
                  rsp_found_ff <= h ? f : 6'd0;
                  rsp_load_ff <= h ? b : 16'd0;
               end
               CMD_FREE: begin
                  rsp_load_ff <= '0;
                  if ({3'b0, ci_ff} >= nc) begin
                     rsp_status_ff <= ST_RANGE;
                     rsp_found_ff <= '0;
                  end else begin
                     rsp_status_ff <= hit_ff ? ST_OK : ST_NONE;
                     rsp_found_ff <= hit_ff ? 6'(best_idx_ff) : 6'd0;
                  end
               end
               CMD_OLDEST: begin
                  rsp_load_ff <= '0;
                  rsp_status_ff <= hit_ff ? ST_OK : ST_NONE;
                  rsp_found_ff <= hit_ff ? 6'(best_idx_ff) : 6'd0;
               end
               CMD_REUSE: begin
                  rsp_load_ff <= '0;
                  rsp_found_ff <= '0;
                  if (cpu_ff > CpuLimit) rsp_status_ff <= ST_CPU;
                  else if ({1'b0, prog_ff} >= progs_ff) rsp_status_ff <= ST_RANGE;
                  else begin
                     rsp_status_ff <= hit_ff ? ST_OK : ST_NONE;
                     rsp_found_ff <= hit_ff ? 6'(best_idx_ff) : 6'd0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_load_value = rsp_load_ff;
endmodule
`default_nettype wire

@@ design/sva_checker.sv @@
// Port-level assertions for the voice allocator and their bind.
// Depends on sva_pkg and synth_voice_allocator_top.
`default_nettype none
module sva_checker import sva_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [5:0]  rsp_found_index,
   input wire logic [15:0] rsp_load_value
);
   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response waits");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_found_index == 6'd0 && rsp_load_value == 16'd0)
      else $error("failed response carries data");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule

bind synth_voice_allocator_top sva_checker u_sva_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_found_index, .rsp_load_value
);
`default_nettype wire
